/* rtl/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/smc_pkg.sv */
// ----------------------------------------------------------------------------
// smc_pkg
// types and constants shared by the stack machine core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smc_pkg;
  localparam int PcW = 18;
  localparam int SpW = 19;
  localparam int WordW = 64;

  localparam logic [5:0] OP_LEA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_CALL = 6'd3,
    OP_JZ = 6'd4, OP_JNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7, OP_LEV = 6'd8,
    OP_LI = 6'd9, OP_LC = 6'd10, OP_SI = 6'd11, OP_SC = 6'd12, OP_PUSH = 6'd13,
    OP_OR = 6'd14, OP_XOR = 6'd15, OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18,
    OP_LT = 6'd19, OP_GT = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23,
    OP_SHR = 6'd24, OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27,
    OP_DIV = 6'd28, OP_MOD = 6'd29, OP_EXIT = 6'd37;

  localparam logic [2:0] ST_RUN = 3'd0, ST_EXIT = 3'd1, ST_UNSUP = 3'd2,
    ST_DIVZ = 3'd3, ST_ADDR = 3'd4;

  localparam logic CFG_STACK_TOP = 1'b0;
  localparam logic CFG_ENTRY_PC = 1'b1;

  typedef struct packed {
    logic [5:0]         op;
    logic signed [63:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [17:0]        next_pc;
    logic signed [63:0] acc;
    logic signed [63:0] exit_value;
    logic [2:0]         status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic mem_rd;
    logic mem_wr;
    logic rd_sel;
    logic use_rd;
    logic mul_start;
    logic div_start;
    logic commit;
    logic fault;
  } smc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] op;
    logic       halted;
    logic       addr_bad;
    logic       div_zero;
    logic       unsup;
    logic       need_rd;
    logic       need_rd2;
    logic       need_wr;
    logic       is_mul;
    logic       is_div;
    logic       div_done;
  } smc_sts_t;
endpackage

/* rtl/smc_ram.sv */
// ----------------------------------------------------------------------------
// smc_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smc_ram #(
  parameter int Width = 64,
  parameter int Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

/* rtl/smc_divider.sv */
// ----------------------------------------------------------------------------
// smc_divider
// radix-2 signed divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [63:0] rem_o
);
  logic [63:0] q_q, q_d, r_q, r_d, b_q, b_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, na_q, na_d, nq_q, nq_d, done_q, done_d;
  logic [64:0] sh, df;

  always_comb begin
    q_d = q_q; r_d = r_q; b_d = b_q; cnt_d = cnt_q; busy_d = busy_q;
    na_d = na_q; nq_d = nq_q; done_d = 1'b0;
    sh = {r_q, q_q[63]};
    df = sh - {1'b0, b_q};
    if (start_i) begin
      na_d = a_i[63];
      nq_d = a_i[63] ^ b_i[63];
      q_d = a_i[63] ? 64'd0 - a_i : a_i;
      b_d = b_i[63] ? 64'd0 - b_i : b_i;
      r_d = '0;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!df[64]) begin
        r_d = df[63:0];
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = sh[63:0];
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; b_q <= b_d; na_q <= na_d; nq_q <= nq_d;
  end

  assign done_o = done_q;
  assign quot_o = nq_q ? 64'd0 - q_q : q_q;
  assign rem_o  = na_q ? 64'd0 - r_q : r_q;
endmodule

/* rtl/smc_datapath.sv */
// ----------------------------------------------------------------------------
// smc_datapath
// machine registers, memory port, alu, multiplier and divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smc_datapath #(
  parameter int MemWords = 32768
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [63:0]      cfg_data_i,
  input  smc_pkg::in_item_t  item_i,
  input  smc_pkg::smc_cmd_t  cmd_i,
  output smc_pkg::smc_sts_t  sts_o,
  output smc_pkg::out_item_t res_o
);
  import smc_pkg::*;
  localparam int AW = $clog2(MemWords);

  logic [PcW-1:0] pc_q, pc_d;
  logic [63:0]    ax_q, ax_d, ev_q, ev_d, opnd_q, t_q, t2_q, mul_q;
  logic [SpW-1:0] sp_q, sp_d, bp_q, bp_d;
  logic [2:0]     st_q, st_d;
  logic [5:0]     op_q;

  logic [SpW-1:0] nsp, bp8;
  logic [PcW-1:0] ret_pc;
  logic [63:0]    rdata, wdata, t, sc_word, raddr_full, axn, dq, dr;
  logic [AW-1:0]  maddr;
  logic           ddone, bad;
  logic [5:0]     lane_sh;

  function automatic logic ok(input logic [63:0] a);
    ok = (a >> 3) < 64'(MemWords);
  endfunction

  assign nsp    = sp_q - SpW'(8);
  assign bp8    = bp_q + SpW'(8);
  assign ret_pc = pc_q + PcW'(16);
  assign t      = t_q;

  // address of each memory access, chosen by opcode and pass
  always_comb begin
    raddr_full = 64'(sp_q);
    case (op_q)
      OP_CALL, OP_ENT, OP_PUSH: raddr_full = 64'(nsp);
      OP_LEV:  raddr_full = cmd_i.rd_sel ? 64'(bp8) : 64'(bp_q);
      OP_LI, OP_LC: raddr_full = ax_q;
      OP_SI, OP_SC: raddr_full = cmd_i.rd_sel ? t_q : 64'(sp_q);
      default: raddr_full = 64'(sp_q);
    endcase
  end
  assign maddr = raddr_full[AW+2:3];

  assign lane_sh = {t_q[2:0], 3'b000};
  assign sc_word = (t2_q & ~(64'hFF << lane_sh)) | ({56'd0, ax_q[7:0]} << lane_sh);
  always_comb begin
    case (op_q)
      OP_CALL: wdata = 64'(ret_pc);
      OP_ENT:  wdata = 64'(bp_q);
      OP_SC:   wdata = sc_word;
      default: wdata = ax_q;
    endcase
  end

  smc_ram #(.Width(64), .Depth(MemWords)) u_ram (
    .clk_i, .we_i(cmd_i.mem_wr), .addr_i(maddr), .wdata_i(wdata), .rdata_o(rdata)
  );

  smc_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .a_i(t_q), .b_i(ax_q),
    .done_o(ddone), .quot_o(dq), .rem_o(dr)
  );

  // address checks for the op in hand
  always_comb begin
    bad = 1'b0;
    case (op_q)
      OP_CALL, OP_ENT, OP_PUSH: bad = !ok(64'(nsp));
      OP_LEV:  bad = !ok(64'(bp_q)) || !ok(64'(bp8));
      OP_LI, OP_LC: bad = !ok(ax_q);
      OP_SI, OP_SC: bad = !ok(64'(sp_q)) || (cmd_i.rd_sel && !ok(t_q));
      default: bad = !ok(64'(sp_q));
    endcase
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.halted   = st_q != ST_RUN;
    sts_o.addr_bad = bad;
    sts_o.div_zero = ax_q == 64'd0;
    sts_o.unsup    = !(op_q <= OP_MOD || op_q == OP_EXIT);
    sts_o.need_rd  = op_q == OP_LEV || op_q == OP_LI || op_q == OP_LC || op_q == OP_SI ||
                     op_q == OP_SC || op_q == OP_EXIT || (op_q >= OP_OR && op_q <= OP_MOD);
    sts_o.need_rd2 = op_q == OP_LEV || op_q == OP_SI || op_q == OP_SC;
    sts_o.need_wr  = op_q == OP_CALL || op_q == OP_ENT || op_q == OP_PUSH ||
                     op_q == OP_SI || op_q == OP_SC;
    sts_o.is_mul   = op_q == OP_MUL;
    sts_o.is_div   = op_q == OP_DIV || op_q == OP_MOD;
    sts_o.div_done = ddone;
  end

  // architectural next state
  always_comb begin
    pc_d = pc_q + PcW'(8); ax_d = ax_q; sp_d = sp_q; bp_d = bp_q; ev_d = ev_q; st_d = st_q;
    axn = ax_q;
    case (op_q)
      OP_LEA: begin axn = 64'(bp_q) + (opnd_q << 3); pc_d = pc_q + PcW'(16); end
      OP_IMM: begin axn = opnd_q; pc_d = pc_q + PcW'(16); end
      OP_JMP: pc_d = opnd_q[PcW-1:0];
      OP_CALL: begin sp_d = nsp; pc_d = opnd_q[PcW-1:0]; end
      OP_JZ:  pc_d = (ax_q != 0) ? pc_q + PcW'(16) : opnd_q[PcW-1:0];
      OP_JNZ: pc_d = (ax_q != 0) ? opnd_q[PcW-1:0] : pc_q + PcW'(16);
      OP_ENT: begin
        bp_d = nsp; sp_d = nsp - SpW'(opnd_q << 3); pc_d = pc_q + PcW'(16);
      end
      OP_ADJ: begin sp_d = sp_q + SpW'(opnd_q << 3); pc_d = pc_q + PcW'(16); end
      OP_LEV: begin bp_d = t_q[SpW-1:0]; pc_d = t2_q[PcW-1:0]; sp_d = bp_q + SpW'(16); end
      OP_LI:  axn = t_q;
      OP_LC:  axn = {{56{t_q[{ax_q[2:0], 3'b111}]}}, 8'((t_q >> {ax_q[2:0], 3'b000}))};
      OP_SI:  sp_d = sp_q + SpW'(8);
      OP_SC:  begin axn = {{56{ax_q[7]}}, ax_q[7:0]}; sp_d = sp_q + SpW'(8); end
      OP_PUSH: sp_d = nsp;
      OP_EXIT: begin ev_d = t_q; st_d = ST_EXIT; end
      default: begin
        sp_d = sp_q + SpW'(8);
        case (op_q)
          OP_OR:  axn = t | ax_q;
          OP_XOR: axn = t ^ ax_q;
          OP_AND: axn = t & ax_q;
          OP_EQ:  axn = 64'(t == ax_q);
          OP_NE:  axn = 64'(t != ax_q);
          OP_LT:  axn = 64'($signed(t) < $signed(ax_q));
          OP_GT:  axn = 64'($signed(ax_q) < $signed(t));
          OP_LE:  axn = 64'(!($signed(ax_q) < $signed(t)));
          OP_GE:  axn = 64'(!($signed(t) < $signed(ax_q)));
          OP_SHL: axn = t << ax_q[5:0];
          OP_SHR: axn = 64'($signed(t) >>> ax_q[5:0]);
          OP_ADD: axn = t + ax_q;
          OP_SUB: axn = t - ax_q;
          OP_MUL: axn = mul_q;
          OP_DIV: axn = dq;
          default: axn = dr;
        endcase
      end
    endcase
    ax_d = axn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; ax_q <= '0; sp_q <= SpW'(262144); bp_q <= SpW'(262144);
      ev_q <= '0; st_q <= ST_RUN; op_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_STACK_TOP) begin
          sp_q <= cfg_data_i[SpW-1:0]; bp_q <= cfg_data_i[SpW-1:0];
        end else begin
          pc_q <= cfg_data_i[PcW-1:0];
        end
      end
      if (cmd_i.load_item) op_q <= item_i.op;
      if (cmd_i.fault) begin
        if (st_q == ST_RUN) begin
          st_q <= (op_q == OP_EXIT || op_q <= OP_MOD) ?
                  ((sts_o.is_div && !bad && ax_q == 0) ? ST_DIVZ : ST_ADDR) : ST_UNSUP;
        end
      end else if (cmd_i.commit) begin
        pc_q <= pc_d; ax_q <= ax_d; sp_q <= sp_d; bp_q <= bp_d; ev_q <= ev_d; st_q <= st_d;
      end
    end
  end

  // 64 bit product: three 32x32 partials are registered, then their sum is registered in mul_q
  logic [63:0] p_ll, p_lh, p_hl;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) opnd_q <= item_i.operand;
    if (cmd_i.use_rd) begin
      if (cmd_i.rd_sel) t2_q <= rdata;
      else t_q <= rdata;
    end
    if (cmd_i.mul_start) begin
      p_ll <= t_q[31:0] * ax_q[31:0];
      p_lh <= t_q[31:0] * ax_q[63:32];
      p_hl <= t_q[63:32] * ax_q[31:0];
    end
    mul_q <= p_ll + {p_lh[31:0], 32'd0} + {p_hl[31:0], 32'd0};
  end

  assign res_o.next_pc    = pc_q;
  assign res_o.acc        = ax_q;
  assign res_o.exit_value = (st_q == ST_EXIT) ? ev_q : 64'd0;
  assign res_o.status     = st_q;
endmodule

/* rtl/smc_ctrl.sv */
// ----------------------------------------------------------------------------
// smc_ctrl
// sequencer for one instruction: fetch, memory passes, execute, deliver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  smc_pkg::smc_sts_t sts_i,
  output smc_pkg::smc_cmd_t cmd_o,
  output logic              cfg_ready_o
);
  import smc_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_RD1 = 4'd2, S_RD1W = 4'd3,
    S_CHK2 = 4'd4, S_RD2W = 4'd5, S_MUL1 = 4'd6, S_MUL2 = 4'd7, S_DIV = 4'd8,
    S_EXE = 4'd9, S_OUT = 4'd10;
  logic [3:0] state_q, state_d;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign cfg_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load_item = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.halted) state_d = S_OUT;
        else if (sts_i.unsup) begin cmd_o.fault = 1'b1; state_d = S_OUT; end
        else if ((sts_i.need_rd || sts_i.need_wr) && sts_i.addr_bad) begin
          cmd_o.fault = 1'b1; state_d = S_OUT;
        end else if (sts_i.is_div && sts_i.div_zero) begin
          cmd_o.fault = 1'b1; state_d = S_OUT;
        end else if (sts_i.need_rd) state_d = S_RD1W;
        else begin
          cmd_o.mem_wr = sts_i.need_wr;
          cmd_o.commit = 1'b1;
          state_d = S_OUT;
        end
      end
      S_RD1W: begin
        cmd_o.use_rd = 1'b1;
        state_d = sts_i.need_rd2 ? S_CHK2 : (sts_i.is_mul ? S_MUL1 :
                  (sts_i.is_div ? S_RD1 : S_EXE));
      end
      S_RD1: begin cmd_o.div_start = 1'b1; state_d = S_DIV; end
      S_CHK2: begin
        cmd_o.rd_sel = 1'b1;
        if (sts_i.addr_bad) begin cmd_o.fault = 1'b1; state_d = S_OUT; end
        else state_d = S_RD2W;
      end
      S_RD2W: begin
        cmd_o.rd_sel = 1'b1; cmd_o.use_rd = 1'b1; state_d = S_EXE;
      end
      S_MUL1: begin cmd_o.mul_start = 1'b1; state_d = S_MUL2; end
      S_MUL2: state_d = S_EXE;
      S_DIV: if (sts_i.div_done) state_d = S_EXE;
      S_EXE: begin
        cmd_o.rd_sel = 1'b1;
        cmd_o.mem_wr = sts_i.need_wr;
        cmd_o.commit = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule

/* rtl/stack_machine_core_unit.sv */
// ----------------------------------------------------------------------------
// stack_machine_core_unit
// stack virtual machine core running one instruction per item
//
// channel   direction  handshake       payload
// in        input      valid / stall   smc_pkg::in_item_t
// out       output     valid / stall   smc_pkg::out_item_t
// cfg       input      valid / ready   index, 64 bit data
//
// register and push-type ops read no memory, lev/si/sc read two words, others one
// mul waits on a product split over two registers, div/mod on the radix-2 divider
// one item in flight; the single-port word ram sets the pass count
// reset loads pc 0 and both pointers to 262144; memory contents undefined
// out stall holds the result and blocks the next item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stack_machine_core_unit #(
  parameter int MemWords = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  smc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output smc_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import smc_pkg::*;
  smc_cmd_t cmd;
  smc_sts_t sts;

  smc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd), .cfg_ready_o
  );

  smc_datapath #(.MemWords(MemWords)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_idx_i(cfg_index_i[0]),
    .cfg_data_i, .item_i(in_item_i), .cmd_i(cmd), .sts_o(sts), .res_o(out_item_o)
  );
endmodule

/* rtl/smc_checker.sv */
// ----------------------------------------------------------------------------
// smc_checker
// port level checks for the stack machine core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input smc_pkg::out_item_t out_item_o
);
  import smc_pkg::*;
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))
  `ASSERT_IMPL(a_one_item, clk_i, rst_ni, out_valid_o, in_stall_o)
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPL(a_exit_zero, clk_i, rst_ni,
    out_valid_o && out_item_o.status != ST_EXIT, out_item_o.exit_value == 64'd0)
endmodule

bind stack_machine_core_unit smc_checker u_chk (.*);

/* verif/stack_machine_core_unit_tb.sv */
// ----------------------------------------------------------------------------
// stack_machine_core_unit_tb
// self-checking bench for the stack machine core: a scoreboard class predicts
// every result from its own copy of registers and memory, and picks only
// programs that stay in range until a single closing fault or exit. Both
// channels idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stack_machine_core_unit_tb;
  import smc_pkg::*;

  localparam logic [63:0] ADDR_LIMIT = 64'd262144;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

  class smc_scoreboard;
    logic [17:0] pc, entry;
    logic [18:0] sp, bp, top;
    logic [63:0] ax, saved;
    logic [2:0]  halt;
    logic [63:0] mem[int];
    int          written[$];
    out_item_t   pending[$];
    int          fails;
    bit          unread;

    function new();
      top = 19'd262144; entry = '0; pc = '0; sp = top; bp = top;
      ax = '0; saved = '0; halt = ST_RUN; fails = 0;
    endfunction

    function void write_reg(logic idx, logic [63:0] d);
      if (idx == CFG_STACK_TOP) begin
        top = d[18:0]; sp = top; bp = top;
      end else begin
        entry = d[17:0]; pc = entry;
      end
    endfunction

    function bit in_range(logic [63:0] a);
      return a < ADDR_LIMIT;
    endfunction

    function logic [63:0] rd(logic [63:0] a);
      int w;
      w = int'(a >> 3);
      if (!mem.exists(w)) begin
        unread = 1;
        return '0;
      end
      return mem[w];
    endfunction

    function logic [63:0] sext8(logic [63:0] v);
      return {{56{v[7]}}, v[7:0]};
    endfunction

    function logic [63:0] div_rem(logic [63:0] a, logic [63:0] b, bit want_rem);
      logic [63:0] ua, ub, q, r;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (want_rem) return a[63] ? -r : r;
      return (a[63] != b[63]) ? -q : q;
    endfunction

    // executes one instruction; state changes only when commit is set
    function logic [2:0] run(in_item_t it, bit commit);
      logic [63:0] opnd, nx, x, t, a, ev, wd, pc64;
      logic [18:0] s, b, nsp;
      logic [2:0]  st;
      bit          we;
      int          wa, sh;
      unread = 0;
      if (halt != ST_RUN) return halt;
      opnd = it.operand; x = ax; s = sp; b = bp; pc64 = {46'b0, pc};
      nx = pc64 + 8; st = ST_RUN; we = 0; ev = '0; wa = 0; wd = '0;
      case (it.op)
        OP_LEA: begin
          x = {45'b0, b} + opnd * 8; nx = pc64 + 16;
        end
        OP_IMM: begin
          x = opnd; nx = pc64 + 16;
        end
        OP_JMP: nx = opnd;
        OP_CALL: begin
          nsp = s - 19'd8;
          if (!in_range({45'b0, nsp})) st = ST_ADDR;
          else begin
            we = 1; wa = int'(nsp >> 3); wd = {46'b0, pc + 18'd16}; s = nsp; nx = opnd;
          end
        end
        OP_JZ: nx = (x != 0) ? pc64 + 16 : opnd;
        OP_JNZ: nx = (x != 0) ? opnd : pc64 + 16;
        OP_ENT: begin
          nsp = s - 19'd8;
          if (!in_range({45'b0, nsp})) st = ST_ADDR;
          else begin
            we = 1; wa = int'(nsp >> 3); wd = {45'b0, b};
            b = nsp; s = nsp - {opnd[15:0], 3'b0}; nx = pc64 + 16;
          end
        end
        OP_ADJ: begin
          s = s + {opnd[15:0], 3'b0}; nx = pc64 + 16;
        end
        OP_LEV: begin
          if (!in_range({45'b0, bp}) || !in_range({45'b0, bp + 19'd8})) st = ST_ADDR;
          else begin
            t = rd({45'b0, bp});
            nx = rd({45'b0, bp + 19'd8});
            b = t[18:0]; s = bp + 19'd16;
          end
        end
        OP_LI: begin
          if (!in_range(x)) st = ST_ADDR;
          else x = rd(x);
        end
        OP_LC: begin
          if (!in_range(x)) st = ST_ADDR;
          else begin
            t = rd(x); x = sext8(t >> (x[2:0] * 8));
          end
        end
        OP_SI, OP_SC: begin
          if (!in_range({45'b0, s})) st = ST_ADDR;
          else begin
            a = rd({45'b0, s});
            if (!in_range(a)) st = ST_ADDR;
            else begin
              we = 1; wa = int'(a >> 3);
              if (it.op == OP_SI) wd = x;
              else begin
                t = rd(a); sh = a[2:0] * 8;
                wd = (t & ~(64'hFF << sh)) | ((x & 64'hFF) << sh);
                x = sext8(x);
              end
              s = s + 19'd8;
            end
          end
        end
        OP_PUSH: begin
          nsp = s - 19'd8;
          if (!in_range({45'b0, nsp})) st = ST_ADDR;
          else begin
            we = 1; wa = int'(nsp >> 3); wd = x; s = nsp;
          end
        end
        OP_EXIT: begin
          if (!in_range({45'b0, s})) st = ST_ADDR;
          else begin
            ev = rd({45'b0, s}); st = ST_EXIT;
          end
        end
        default: begin
          if (it.op < OP_OR || it.op > OP_MOD) st = ST_UNSUP;
          else if (!in_range({45'b0, s})) st = ST_ADDR;
          else if ((it.op == OP_DIV || it.op == OP_MOD) && x == 0) st = ST_DIVZ;
          else begin
            t = rd({45'b0, s});
            case (it.op)
              OP_OR:  x = t | x;
              OP_XOR: x = t ^ x;
              OP_AND: x = t & x;
              OP_EQ:  x = {63'b0, t == x};
              OP_NE:  x = {63'b0, t != x};
              OP_LT:  x = {63'b0, $signed(t) < $signed(x)};
              OP_GT:  x = {63'b0, $signed(x) < $signed(t)};
              OP_LE:  x = {63'b0, !($signed(x) < $signed(t))};
              OP_GE:  x = {63'b0, !($signed(t) < $signed(x))};
              OP_SHL: x = t << x[5:0];
              OP_SHR: x = 64'($signed(t) >>> x[5:0]);
              OP_ADD: x = t + x;
              OP_SUB: x = t - x;
              OP_MUL: x = t * x;
              OP_DIV: x = div_rem(t, x, 0);
              default: x = div_rem(t, x, 1);
            endcase
            s = s + 19'd8;
          end
        end
      endcase
      if (commit) begin
        if (st >= ST_UNSUP) halt = st;
        else begin
          pc = nx[17:0]; ax = x; sp = s; bp = b;
          if (we) begin
            if (!mem.exists(wa)) written.push_back(wa);
            mem[wa] = wd;
          end
          if (st == ST_EXIT) begin
            halt = ST_EXIT; saved = ev;
          end
        end
      end
      return st;
    endfunction

    function void note_item(in_item_t it);
      out_item_t e;
      void'(run(it, 1));
      e.next_pc = pc;
      e.acc = ax;
      e.exit_value = (halt == ST_EXIT) ? saved : '0;
      e.status = halt;
      pending.push_back(e);
    endfunction

    function void check_result(out_item_t o);
      out_item_t e;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result item pc=%h status=%0d", o.next_pc, o.status);
        return;
      end
      e = pending.pop_front();
      if (o.next_pc !== e.next_pc || o.acc !== e.acc || o.exit_value !== e.exit_value ||
          o.status !== e.status) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: exp pc=%h acc=%h exit=%h st=%0d / got pc=%h acc=%h exit=%h st=%0d",
                   e.next_pc, e.acc, e.exit_value, e.status,
                   o.next_pc, o.acc, o.exit_value, o.status);
      end
    endfunction
  endclass

  logic      clk_i, rst_ni;
  logic      in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_item_t  in_item_i;
  out_item_t out_item_o;
  logic      cfg_valid_i, cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  smc_scoreboard sb;
  bit quiet, hold_req;

  stack_machine_core_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("[stack_machine_core_unit] ERROR");
    $finish;
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end
      n = quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  task automatic send_op(logic [5:0] op, logic [63:0] operand);
    in_item_t it;
    it.op = op;
    it.operand = operand;
    send_item(it);
  endtask

  task automatic write_cfg(logic idx, logic [63:0] d);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] extremes[5];
    extremes = '{MIN64, ~MIN64, 64'd0, '1, 64'd1};
    case ($urandom_range(0, 6))
      0: return rand64();
      1: return extremes[$urandom_range(0, 4)];
      2, 3: begin
        if (sb.written.size() == 0) return 64'd0;
        return {sb.written[$urandom_range(0, sb.written.size() - 1)], 3'b0} +
               $urandom_range(0, 7);
      end
      4: return 64'($urandom_range(0, 70));
      5: return {45'b0, sb.sp};
      default: return -64'($urandom_range(1, 70));
    endcase
  endfunction

  // random instruction that neither faults nor reads a word never written
  function automatic in_item_t pick_item();
    in_item_t it;
    repeat (40) begin
      if ($urandom_range(0, 9) < 3) it.op = ($urandom_range(0, 1) != 0) ? OP_IMM : OP_PUSH;
      else it.op = 6'($urandom_range(0, 29));
      case (it.op)
        OP_IMM: it.operand = pick_value();
        OP_JMP, OP_CALL, OP_JZ, OP_JNZ:
          it.operand = ($urandom_range(0, 1) != 0) ? rand64() : 64'($urandom_range(0, 262143));
        OP_ENT, OP_ADJ: it.operand = ($urandom_range(0, 9) == 0) ? rand64() :
                                     64'($urandom_range(0, 12)) - 64'd4;
        default: it.operand = ($urandom_range(0, 1) != 0) ? rand64() :
                              64'($urandom_range(0, 20)) - 64'd10;
      endcase
      if (sb.run(it, 0) == ST_RUN && !sb.unread) return it;
    end
    it.op = OP_IMM;
    it.operand = rand64();
    return it;
  endfunction

  initial begin
    logic [18:0] tops[5];
    logic [17:0] pcs[5];
    in_item_t it;
    int kind;
    sb = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed program on reset settings
    send_op(OP_LEA, -64'd2);
    send_op(OP_IMM, MIN64);  send_op(OP_PUSH, 0); send_op(OP_IMM, '1); send_op(OP_DIV, 0);
    send_op(OP_PUSH, 0);     send_op(OP_IMM, '1); send_op(OP_MOD, 0);
    send_op(OP_IMM, -64'h80); send_op(OP_PUSH, 0); send_op(OP_IMM, 64'd127); send_op(OP_SHR, 0);
    send_op(OP_IMM, 64'd262136); send_op(OP_PUSH, 0); send_op(OP_IMM, 64'h1FF);
    send_op(OP_SC, 0);
    send_op(OP_IMM, 64'd262136); send_op(OP_LC, 0);
    send_op(OP_CALL, 64'h40); send_op(OP_ENT, 64'd2); send_op(OP_ADJ, 64'd2);
    send_op(OP_LEV, 0);
    send_op(OP_IMM, 64'd262136); send_op(OP_PUSH, 0); send_op(OP_IMM, 64'd5);
    send_op(OP_SI, 0);
    send_op(OP_IMM, 64'd262136); send_op(OP_LI, 0);
    send_op(OP_JZ, 64'h3FFFF); send_op(OP_JNZ, 64'h3FFFF); send_op(OP_JMP, '1);

    tops = '{19'd262144, 19'd0, 19'd8, 19'd131072 + 19'($urandom_range(0, 65535)),
             19'd200000};
    pcs = '{18'd262143, 18'd0, 18'($urandom_range(0, 262143)), 18'd4, 18'd100};
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(CFG_STACK_TOP, {45'b0, tops[ph]});
      write_cfg(CFG_ENTRY_PC, {46'b0, pcs[ph]});
      for (int i = 0; i < 135; i++) begin
        if (ph == 2 && i == 50) hold_req = 1;
        quiet = (ph == 3 && i < 40);
        send_item(pick_item());
      end
      quiet = 0;
    end

    // closing fault or exit, then a few items on the halted core
    write_cfg(CFG_STACK_TOP, 64'd4096 + 64'($urandom_range(0, 4096)));
    write_cfg(CFG_ENTRY_PC, 64'($urandom_range(0, 262143)));
    send_op(OP_IMM, rand64());
    send_op(OP_PUSH, 0);
    kind = $urandom_range(0, 3);
    case (kind)
      0: send_op(OP_EXIT, rand64());
      1: begin
        it.op = 6'($urandom_range(30, 62));
        if (it.op >= OP_EXIT) it.op = it.op + 6'd1;
        send_op(it.op, rand64());
      end
      2: begin
        send_op(OP_IMM, 0);
        send_op(($urandom_range(0, 1) != 0) ? OP_DIV : OP_MOD, 0);
      end
      default: begin
        send_op(OP_IMM, ADDR_LIMIT + 64'($urandom_range(0, 100000)));
        send_op(($urandom_range(0, 1) != 0) ? OP_LI : OP_LC, 0);
      end
    endcase
    repeat (4) send_op(6'($urandom_range(0, 63)), rand64());
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0) $display("[stack_machine_core_unit] OK");
    else $display("[stack_machine_core_unit] ERROR");
    $finish;
  end
endmodule
